// File: hdl/dcwd_pkg.sv
// dcwd_pkg: shared types and constants for the double-click window detector
// no dependencies; used by double_click_window_detector
`timescale 1ns / 1ps

package dcwd_pkg;

  // operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_TICK    = 2'd1,
    OP_CONSUME = 2'd2
  } op_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_WINDOW_TICKS       = 2'd0,
    CFG_LONG_PRESS_TICKS   = 2'd1,
    CFG_DOUBLE_CLICK_TICKS = 2'd2
  } cfg_idx_t;

  localparam int unsigned CFG_WIDTH = 16;

  // register values after reset
  localparam logic [CFG_WIDTH-1:0] WINDOW_TICKS_RST       = 16'd300;
  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_TICKS_RST   = 16'd80;
  localparam logic [CFG_WIDTH-1:0] DOUBLE_CLICK_TICKS_RST = 16'd40;

endpackage

// File: hdl/double_click_window_detector.sv
// double_click_window_detector: top level, window timing and click detection
// depends on dcwd_pkg (op codes, register indexes, reset values)
`timescale 1ns / 1ps

// Usage
//   in_*  : one transaction per command: start window, sample tick or consume.
//           A sample tick carries the debounced button level (1 released).
//   out_* : exactly one result transaction per input transaction, in order,
//           with the latched double-click flag and the window state.
//   cfg_* : register writes (window length, long-press limit, double-click
//           gap), always ready. The user writes only while no transaction
// is in flight; the block does not enforce it. The result is in the output
// register on the cycle after acceptance. Throughput is one transaction per
// cycle unless out_ready stalls, set by the single state update in between.
// in_ready stays high while the output register is empty or being taken, so
// a stalled receiver holds off new input after one result is parked.
// Synchronous reset loads the default register values, closes the window,
// clears the latch and click history and empties the output register.
module double_click_window_detector #(
  parameter int unsigned TIME_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_operation,
  input  logic                          in_button_released,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_toggle_requested,
  output logic                          out_window_open,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [dcwd_pkg::CFG_WIDTH-1:0] cfg_data
);

  localparam int unsigned CW =
    (TIME_WIDTH > dcwd_pkg::CFG_WIDTH) ? TIME_WIDTH : dcwd_pkg::CFG_WIDTH;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

  // configuration registers
  logic [dcwd_pkg::CFG_WIDTH-1:0] window_ticks_r;
  logic [dcwd_pkg::CFG_WIDTH-1:0] long_press_ticks_r;
  logic [dcwd_pkg::CFG_WIDTH-1:0] double_click_ticks_r;

  // detector state
  logic                  previous_level_r, previous_level_nxt;
  logic [TIME_WIDTH-1:0] tick_count_r, tick_count_nxt;
  logic                  press_valid_r, press_valid_nxt;
  logic [TIME_WIDTH-1:0] press_time_r, press_time_nxt;
  logic                  click_valid_r, click_valid_nxt;
  logic [TIME_WIDTH-1:0] click_release_time_r, click_release_time_nxt;
  logic                  toggle_latch_r, toggle_latch_nxt;
  logic                  window_active_r, window_active_nxt;

  // output register
  logic out_valid_r, out_valid_nxt;
  logic out_toggle_r, out_toggle_nxt;
  logic out_window_r, out_window_nxt;

  logic               in_fire;
  dcwd_pkg::op_t      op;
  logic [TIME_WIDTH-1:0] duration;
  logic [TIME_WIDTH-1:0] gap_old;
  logic [TIME_WIDTH-1:0] gap_new;
  logic               latch_hit;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign op        = dcwd_pkg::op_t'(in_operation);

  assign out_valid            = out_valid_r;
  assign out_toggle_requested = out_toggle_r;
  assign out_window_open      = out_window_r;

  // elapsed times, modulo the time width
  assign duration = tick_count_r - press_time_r;
  assign gap_old  = tick_count_r - click_release_time_r;

  // next detector state for the accepted transaction
  always_comb begin
    previous_level_nxt     = previous_level_r;
    tick_count_nxt         = tick_count_r;
    press_valid_nxt        = press_valid_r;
    press_time_nxt         = press_time_r;
    click_valid_nxt        = click_valid_r;
    click_release_time_nxt = click_release_time_r;
    toggle_latch_nxt       = toggle_latch_r;
    window_active_nxt      = window_active_r;
    latch_hit              = 1'b0;
    gap_new                = '0;
    if (in_fire) begin
      case (op)
        dcwd_pkg::OP_START: begin
          previous_level_nxt     = in_button_released;
          tick_count_nxt         = '0;
          press_valid_nxt        = 1'b0;
          press_time_nxt         = '0;
          click_valid_nxt        = 1'b0;
          click_release_time_nxt = '0;
          toggle_latch_nxt       = 1'b0;
          window_active_nxt      = (window_ticks_r != '0);
        end
        dcwd_pkg::OP_TICK: begin
          if (window_active_r) begin
            // edge handling
            if (previous_level_r && !in_button_released) begin
              press_valid_nxt = 1'b1;
              press_time_nxt  = tick_count_r;
            end else if (!previous_level_r && in_button_released && press_valid_r) begin
              press_valid_nxt = 1'b0;
              if (CW'(duration) < CW'(long_press_ticks_r)) begin
                if (click_valid_r && CW'(gap_old) <= CW'(double_click_ticks_r)) begin
                  toggle_latch_nxt  = 1'b1;
                  window_active_nxt = 1'b0;
                  latch_hit         = 1'b1;
                end else begin
                  click_valid_nxt        = 1'b1;
                  click_release_time_nxt = tick_count_r;
                end
              end else begin
                click_valid_nxt = 1'b0;
              end
            end
            // expiry, level tracking and window timing
            if (!latch_hit) begin
              gap_new = tick_count_r - click_release_time_nxt;
              if (click_valid_nxt && CW'(gap_new) > CW'(double_click_ticks_r)) begin
                click_valid_nxt = 1'b0;
              end
              previous_level_nxt = in_button_released;
              if (tick_count_r != TIME_MAX) begin
                tick_count_nxt = tick_count_r + 1'b1;
              end
              if (CW'(tick_count_nxt) >= CW'(window_ticks_r)) begin
                window_active_nxt = 1'b0;
              end
            end
          end
        end
        dcwd_pkg::OP_CONSUME: begin
          toggle_latch_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // result of the accepted transaction
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_toggle_nxt = out_toggle_r;
    out_window_nxt = out_window_r;
    if (in_fire) begin
      out_valid_nxt  = 1'b1;
      out_toggle_nxt = (op == dcwd_pkg::OP_CONSUME) ? toggle_latch_r : toggle_latch_nxt;
      out_window_nxt = window_active_nxt;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ticks_r       <= dcwd_pkg::WINDOW_TICKS_RST;
      long_press_ticks_r   <= dcwd_pkg::LONG_PRESS_TICKS_RST;
      double_click_ticks_r <= dcwd_pkg::DOUBLE_CLICK_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (dcwd_pkg::cfg_idx_t'(cfg_index))
        dcwd_pkg::CFG_WINDOW_TICKS:       window_ticks_r       <= cfg_data;
        dcwd_pkg::CFG_LONG_PRESS_TICKS:   long_press_ticks_r   <= cfg_data;
        dcwd_pkg::CFG_DOUBLE_CLICK_TICKS: double_click_ticks_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // detector state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      previous_level_r     <= 1'b1;
      tick_count_r         <= '0;
      press_valid_r        <= 1'b0;
      press_time_r         <= '0;
      click_valid_r        <= 1'b0;
      click_release_time_r <= '0;
      toggle_latch_r       <= 1'b0;
      window_active_r      <= 1'b0;
      out_valid_r          <= 1'b0;
    end else begin
      previous_level_r     <= previous_level_nxt;
      tick_count_r         <= tick_count_nxt;
      press_valid_r        <= press_valid_nxt;
      press_time_r         <= press_time_nxt;
      click_valid_r        <= click_valid_nxt;
      click_release_time_r <= click_release_time_nxt;
      toggle_latch_r       <= toggle_latch_nxt;
      window_active_r      <= window_active_nxt;
      out_valid_r          <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    out_toggle_r <= out_toggle_nxt;
    out_window_r <= out_window_nxt;
  end

endmodule

// File: dv/tb.sv
// tb: self-checking testbench for double_click_window_detector
// depends on dcwd_pkg and hdl/double_click_window_detector.sv; predicts every result in-line
`timescale 1ns / 1ps

module tb;

  localparam int TW = 16;
  // operation code the block does not define; it must be ignored
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // total count of non-ignored input transactions to aim for
  localparam int WORK_TARGET = 1600;

  typedef struct packed {
    logic toggle;
    logic window;
  } click_result_t;

  // clock and block ports
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = dcwd_pkg::OP_START;
  logic in_button_released = 1'b1;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_toggle_requested;
  logic out_window_open;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = dcwd_pkg::CFG_WINDOW_TICKS;
  logic [dcwd_pkg::CFG_WIDTH-1:0] cfg_data = '0;

  // predicted registers
  logic [dcwd_pkg::CFG_WIDTH-1:0] win_len = dcwd_pkg::WINDOW_TICKS_RST;
  logic [dcwd_pkg::CFG_WIDTH-1:0] long_lim = dcwd_pkg::LONG_PRESS_TICKS_RST;
  logic [dcwd_pkg::CFG_WIDTH-1:0] dbl_gap = dcwd_pkg::DOUBLE_CLICK_TICKS_RST;

  // predicted detector state
  logic lvl_prev = 1'b1;
  logic [TW-1:0] ticks = '0;
  logic press_seen = 1'b0;
  logic [TW-1:0] press_at = '0;
  logic click_seen = 1'b0;
  logic [TW-1:0] click_at = '0;
  logic latch = 1'b0;
  logic win_open = 1'b0;

  click_result_t expected_results[$];
  click_result_t head_result;
  click_result_t new_result;
  int mismatches = 0;
  int work_items = 0;
  bit idle_en = 1'b1;
  bit stall_en = 1'b1;
  int rx_hold_req = 0;

  double_click_window_detector #(
    .TIME_WIDTH(TW)
  ) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_button_released  (in_button_released),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_toggle_requested(out_toggle_requested),
    .out_window_open     (out_window_open),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #2 clk = ~clk;

  // run limit, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // one step of the detector for an accepted transaction
  task automatic predict_click(input logic [1:0] op, input logic rel,
                               output click_result_t res);
    logic [TW-1:0] now;
    logic [TW-1:0] span;
    logic done;
    done = 1'b0;
    case (op)
      dcwd_pkg::OP_START: begin
        lvl_prev = rel;
        ticks = '0;
        press_seen = 1'b0;
        press_at = '0;
        click_seen = 1'b0;
        click_at = '0;
        latch = 1'b0;
        win_open = (win_len != '0);
        res.toggle = latch;
      end
      dcwd_pkg::OP_TICK: begin
        if (win_open) begin
          now = ticks;
          if (lvl_prev && !rel) begin
            press_seen = 1'b1;
            press_at = now;
          end else if (!lvl_prev && rel && press_seen) begin
            span = now - press_at;
            press_seen = 1'b0;
            if (span < long_lim) begin
              span = now - click_at;
              if (click_seen && span <= dbl_gap) begin
                // second short click in time: latch and close
                latch = 1'b1;
                win_open = 1'b0;
                done = 1'b1;
              end else begin
                click_seen = 1'b1;
                click_at = now;
              end
            end else begin
              click_seen = 1'b0;
            end
          end
          if (!done) begin
            // stale click expires, then time moves on
            span = now - click_at;
            if (click_seen && span > dbl_gap) click_seen = 1'b0;
            lvl_prev = rel;
            if (ticks != '1) ticks = ticks + 1'b1;
            if (ticks >= win_len) win_open = 1'b0;
          end
        end
        res.toggle = latch;
      end
      dcwd_pkg::OP_CONSUME: begin
        res.toggle = latch;
        latch = 1'b0;
      end
      default: begin
        res.toggle = latch;
      end
    endcase
    res.window = win_open;
  endtask

  task automatic note_mismatch(input string what, input click_result_t exp_res);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected toggle=%0b window=%0b, got toggle=%0b window=%0b",
               $realtime, what, exp_res.toggle, exp_res.window,
               out_toggle_requested, out_window_open);
    end
  endtask

  // result check, register tracking and prediction, all on the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected result", '0);
        end else begin
          head_result = expected_results.pop_front();
          if (head_result.toggle !== out_toggle_requested ||
              head_result.window !== out_window_open) begin
            note_mismatch("result mismatch", head_result);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dcwd_pkg::CFG_WINDOW_TICKS:       win_len = cfg_data;
          dcwd_pkg::CFG_LONG_PRESS_TICKS:   long_lim = cfg_data;
          dcwd_pkg::CFG_DOUBLE_CLICK_TICKS: dbl_gap = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_click(in_operation, in_button_released, new_result);
        expected_results.push_back(new_result);
      end
    end
  end

  // receiver: random stall bursts plus a single on-request long hold
  initial begin
    int hold;
    bit hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0 && !hold_done) begin
        hold = rx_hold_req;
        hold_done = 1'b1;
        out_ready = 1'b0;
        repeat (hold) @(negedge clk);
      end else if (stall_en && $urandom_range(0, 9) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  // send one input transaction; called and returns on a falling edge
  task automatic send_item(input logic [1:0] op, input logic rel);
    if (idle_en && $urandom_range(0, 9) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    if (op == dcwd_pkg::OP_START || op == dcwd_pkg::OP_CONSUME ||
        (op == dcwd_pkg::OP_TICK && win_open)) work_items++;
    in_operation = op;
    in_button_released = rel;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // let every outstanding result drain before touching registers
  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input dcwd_pkg::cfg_idx_t idx,
                           input logic [dcwd_pkg::CFG_WIDTH-1:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(input logic [dcwd_pkg::CFG_WIDTH-1:0] w,
                            input logic [dcwd_pkg::CFG_WIDTH-1:0] l,
                            input logic [dcwd_pkg::CFG_WIDTH-1:0] g);
    wait_idle();
    write_reg(dcwd_pkg::CFG_WINDOW_TICKS, w);
    write_reg(dcwd_pkg::CFG_LONG_PRESS_TICKS, l);
    write_reg(dcwd_pkg::CFG_DOUBLE_CLICK_TICKS, g);
  endtask

  // window closed after reset: ticks ignored, consume and unused op report state
  task automatic test_closed_window();
    send_item(dcwd_pkg::OP_TICK, 1'b0);
    send_item(dcwd_pkg::OP_TICK, 1'b1);
    send_item(dcwd_pkg::OP_CONSUME, 1'b0);
    send_item(OP_UNUSED, 1'b1);
  endtask

  // two quick clicks with reset registers latch and close the window
  task automatic test_double_click();
    send_item(dcwd_pkg::OP_START, 1'b1);
    send_item(dcwd_pkg::OP_TICK, 1'b0);
    send_item(dcwd_pkg::OP_TICK, 1'b1);
    send_item(dcwd_pkg::OP_TICK, 1'b0);
    send_item(dcwd_pkg::OP_TICK, 1'b1);
    send_item(OP_UNUSED, 1'b0);
    send_item(dcwd_pkg::OP_CONSUME, 1'b1);
    send_item(dcwd_pkg::OP_CONSUME, 1'b0);
  endtask

  task automatic test_zero_window();
    wait_idle();
    write_reg(dcwd_pkg::CFG_WINDOW_TICKS, '0);
    send_item(dcwd_pkg::OP_START, 1'b1);
    send_item(dcwd_pkg::OP_TICK, 1'b0);
  endtask

  // release with no press, consume while open, close on the last tick
  task automatic test_window_end();
    wait_idle();
    write_reg(dcwd_pkg::CFG_WINDOW_TICKS, 16'd3);
    send_item(dcwd_pkg::OP_START, 1'b0);
    send_item(dcwd_pkg::OP_TICK, 1'b1);
    send_item(dcwd_pkg::OP_CONSUME, 1'b1);
    send_item(dcwd_pkg::OP_TICK, 1'b1);
    send_item(dcwd_pkg::OP_TICK, 1'b1);
  endtask

  // a long press forgets the earlier click, so the next click does not latch
  task automatic test_long_press();
    set_config(16'hFFFF, 16'd2, 16'hFFFF);
    send_item(dcwd_pkg::OP_START, 1'b1);
    send_item(dcwd_pkg::OP_TICK, 1'b0);
    send_item(dcwd_pkg::OP_TICK, 1'b1);
    send_item(dcwd_pkg::OP_TICK, 1'b0);
    send_item(dcwd_pkg::OP_TICK, 1'b0);
    send_item(dcwd_pkg::OP_TICK, 1'b1);
    send_item(dcwd_pkg::OP_TICK, 1'b0);
    send_item(dcwd_pkg::OP_TICK, 1'b1);
    send_item(dcwd_pkg::OP_CONSUME, 1'b0);
  endtask

  // receiver holds off while the sender keeps offering transactions
  task automatic test_backpressure();
    int i;
    set_config(16'd200, 16'd6, 16'd5);
    idle_en = 1'b0;
    rx_hold_req = 40;
    send_item(dcwd_pkg::OP_START, 1'b1);
    for (i = 0; i < 12; i++) send_item(dcwd_pkg::OP_TICK, i[1]);
    idle_en = 1'b1;
  endtask

  // one window: runs of pressed and released levels sized around the limits
  task automatic run_session(input int max_ticks);
    logic lvl;
    int run;
    int lim;
    int sent;
    int i;
    lvl = ($urandom_range(0, 7) != 0);
    send_item(dcwd_pkg::OP_START, lvl);
    sent = 0;
    while (win_open && sent < max_ticks) begin
      if (lvl) lim = (dbl_gap > 36) ? 40 : int'(dbl_gap) + 4;
      else lim = (long_lim > 36) ? 40 : int'(long_lim) + 4;
      run = $urandom_range(1, lim);
      for (i = 0; i < run && win_open; i++) begin
        if ($urandom_range(0, 24) == 0) begin
          send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end else begin
          send_item(dcwd_pkg::OP_TICK, lvl);
        end
        sent++;
      end
      lvl = ~lvl;
    end
    case ($urandom_range(0, 3))
      0: send_item(dcwd_pkg::OP_TICK, 1'($urandom_range(0, 1)));
      1: send_item(OP_UNUSED, 1'($urandom_range(0, 1)));
      default: send_item(dcwd_pkg::OP_CONSUME, 1'($urandom_range(0, 1)));
    endcase
  endtask

  task automatic test_random();
    int phase;
    int target;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        1: set_config(16'd1, 16'd0, 16'd0);
        2: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: set_config(16'($urandom_range(20, 150)), 16'd0, 16'($urandom_range(1, 25)));
        4: set_config(16'($urandom_range(20, 150)), 16'($urandom_range(2, 25)), 16'd0);
        default: set_config(16'($urandom_range(10, 150)), 16'($urandom_range(1, 30)),
                            16'($urandom_range(0, 30)));
      endcase
      target = work_items + (WORK_TARGET - work_items) / (8 - phase);
      while (work_items < target) begin
        // last phase runs with no idling on either side
        idle_en = (phase != 7) && ($urandom_range(0, 3) != 0);
        stall_en = (phase != 7) && ($urandom_range(0, 3) != 0);
        run_session($urandom_range(10, 120));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_closed_window();
    test_double_click();
    test_zero_window();
    test_window_end();
    test_long_press();
    test_backpressure();
    test_random();
    // drain and finish
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
